[design/ssht_pkg.sv]
// ============================================================================
// ssht_pkg
// Shared types and constants for the segment/sphere hit test.
// ============================================================================
`default_nettype none

package ssht_pkg;

  // configuration register index
  localparam int CFG_ADDR_BITS = 3;
  typedef logic [CFG_ADDR_BITS-1:0] cfg_addr_t;

  localparam cfg_addr_t CFG_CENTER_X     = 3'd0;
  localparam cfg_addr_t CFG_CENTER_Y     = 3'd1;
  localparam cfg_addr_t CFG_CENTER_Z     = 3'd2;
  localparam cfg_addr_t CFG_BODY_RADIUS  = 3'd3;
  localparam cfg_addr_t CFG_BOUND_RADIUS = 3'd4;

  // register stages from input acceptance to the output register
  localparam int PIPE_STAGES = 7;

endpackage

`default_nettype wire

[design/segment_sphere_hit_test.sv]
// An accepted input transaction passes through each stage register in order to
//   out_valid, when the output side does not stall.
// Throughput: one transaction per cycle; the seven stage valid bits collapse
//   bubbles, so input is stalled only when every stage holds a transaction.
// Reset (rst_n low, synchronous): clears all stage valid bits and sets the
//   center and both radius registers to zero.
// ============================================================================
// segment_sphere_hit_test
// Streaming test of a ray segment against a configured sphere, exact integer
// math, seven-stage pipeline.
// ============================================================================
`default_nettype none

module segment_sphere_hit_test
  import ssht_pkg::*;
#(
  parameter int COORD_BITS    = 32,
  parameter int DIR_FRAC_BITS = 14
) (
  input  wire                             clk,
  input  wire                             rst_n,

  // configuration write port
  input  wire                             cfg_wr_en,
  input  wire  [CFG_ADDR_BITS-1:0]        cfg_addr,
  input  wire  [COORD_BITS-1:0]           cfg_data,

  // input transaction
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  signed [COORD_BITS-1:0]    in_origin_x,
  input  wire  signed [COORD_BITS-1:0]    in_origin_y,
  input  wire  signed [COORD_BITS-1:0]    in_origin_z,
  input  wire  signed [DIR_FRAC_BITS+1:0] in_dir_x,
  input  wire  signed [DIR_FRAC_BITS+1:0] in_dir_y,
  input  wire  signed [DIR_FRAC_BITS+1:0] in_dir_z,
  input  wire  [COORD_BITS-2:0]           in_seg_length,

  // result transaction
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic                            out_hit
);

  // --------------------------------------------------------------------------
  // Widths. Everything is scaled by S = 2^DIR_FRAC_BITS, so all values are
  // exact integers and no width below can overflow.
  // --------------------------------------------------------------------------
  localparam int CB   = COORD_BITS;
  localparam int DF   = DIR_FRAC_BITS;
  localparam int DW   = DF + 2;          // direction, Q1.DF signed
  localparam int RW   = CB - 1;          // radius / length, unsigned
  localparam int D0W  = CB + 1;          // C - Q
  localparam int PXW  = D0W + DW;        // d0 * dir
  localparam int LPW  = DW + RW + 1;     // dir * len
  localparam int CRW  = PXW + 1;         // cross product component
  localparam int EW   = LPW + 1;         // end point component, scaled
  localparam int TW   = PXW + 2;         // projection t = d0 . dir
  localparam int AW   = CRW;             // magnitude width (>= EW)
  localparam int H    = (AW + 1) / 2;    // low half for split squaring
  localparam int HIW  = AW - H;          // high half
  localparam int SQW  = 2 * AW;          // one square
  localparam int SUMW = SQW + 2;         // sum of three squares
  localparam int LSQW = 2 * RW;          // radius squared
  localparam int NL   = 6;               // squaring lanes: 3 cross, 3 end

  // --------------------------------------------------------------------------
  // Configuration registers. The squared radii are registered off the
  // config values; they are consumed only at the last stage, well after
  // any write that precedes a transaction.
  // --------------------------------------------------------------------------
  logic signed [CB-1:0] center_r [3];
  logic [RW-1:0]        body_r;
  logic [RW-1:0]        bound_r;
  logic [LSQW-1:0]      body_sq_r;
  logic [LSQW-1:0]      bound_sq_r;
  logic [LSQW-1:0]      body_sq_nxt;
  logic [LSQW-1:0]      bound_sq_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r[0] <= '0;
      center_r[1] <= '0;
      center_r[2] <= '0;
      body_r      <= '0;
      bound_r     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_CENTER_X:     center_r[0] <= $signed(cfg_data);
        CFG_CENTER_Y:     center_r[1] <= $signed(cfg_data);
        CFG_CENTER_Z:     center_r[2] <= $signed(cfg_data);
        CFG_BODY_RADIUS:  body_r      <= cfg_data[RW-1:0];
        CFG_BOUND_RADIUS: bound_r     <= cfg_data[RW-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  assign body_sq_nxt  = LSQW'(body_r)  * LSQW'(body_r);
  assign bound_sq_nxt = LSQW'(bound_r) * LSQW'(bound_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_sq_r  <= '0;
      bound_sq_r <= '0;
    end else begin
      body_sq_r  <= body_sq_nxt;
      bound_sq_r <= bound_sq_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. A stage advances when it is empty or when the
  // stage after it advances; the output register advances when not stalled.
  // Bubbles therefore collapse and a stalled output only backs up the pipe
  // once every stage is full.
  // --------------------------------------------------------------------------
  logic [PIPE_STAGES-1:0] vld_r;
  logic [PIPE_STAGES:0]   adv;

  always_comb begin
    adv[PIPE_STAGES] = !out_stall;
    for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[PIPE_STAGES-1];

  // --------------------------------------------------------------------------
  // Stage 1: d0 = C - Q, capture direction and length.
  // --------------------------------------------------------------------------
  logic signed [CB-1:0]  org [3];
  logic signed [D0W-1:0] d0_nxt   [3];
  logic signed [D0W-1:0] d0_1_r   [3];
  logic signed [DW-1:0]  dir_1_r  [3];
  logic [RW-1:0]         len_1_r;
  logic                  nz_nxt;
  logic                  nz_1_r;

  assign org[0] = in_origin_x;
  assign org[1] = in_origin_y;
  assign org[2] = in_origin_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d0_nxt[i] = D0W'(center_r[i]) - D0W'(org[i]);
    end
  end

  // a zero direction can never fail the between test
  assign nz_nxt = (in_dir_x != '0) || (in_dir_y != '0) || (in_dir_z != '0);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      d0_1_r     <= d0_nxt;
      dir_1_r[0] <= in_dir_x;
      dir_1_r[1] <= in_dir_y;
      dir_1_r[2] <= in_dir_z;
      len_1_r    <= in_seg_length;
      nz_1_r     <= nz_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: all d0[i]*dir[j] products (cross and dot) and dir*len.
  // --------------------------------------------------------------------------
  logic signed [PXW-1:0] pp_nxt  [3][3];
  logic signed [PXW-1:0] pp_2_r  [3][3];
  logic signed [LPW-1:0] dl_nxt  [3];
  logic signed [LPW-1:0] dl_2_r  [3];
  logic signed [RW:0]    len_s;
  logic signed [D0W-1:0] d0_2_r  [3];
  logic [RW-1:0]         len_2_r;
  logic                  nz_2_r;

  assign len_s = $signed({1'b0, len_1_r});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pp_nxt[i][j] = PXW'(d0_1_r[i]) * PXW'(dir_1_r[j]);
      end
      dl_nxt[i] = LPW'(dir_1_r[i]) * LPW'(len_s);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      pp_2_r  <= pp_nxt;
      dl_2_r  <= dl_nxt;
      d0_2_r  <= d0_1_r;
      len_2_r <= len_1_r;
      nz_2_r  <= nz_1_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: cross product, end point offset (w*len - d0*S), projection t
  // and its between test; magnitudes of the six components to be squared.
  // --------------------------------------------------------------------------
  logic signed [CRW-1:0] cr    [3];
  logic signed [EW-1:0]  ec    [3];
  logic signed [AW-1:0]  sv    [NL];
  logic signed [TW-1:0]  tproj;
  logic signed [TW-1:0]  len_sc;
  logic [AW-1:0]         mag_nxt [NL];
  logic [AW-1:0]         mag_3_r [NL];
  logic                  tf_nxt;
  logic                  tf_3_r;

  always_comb begin
    cr[0] = CRW'(pp_2_r[1][2]) - CRW'(pp_2_r[2][1]);
    cr[1] = CRW'(pp_2_r[2][0]) - CRW'(pp_2_r[0][2]);
    cr[2] = CRW'(pp_2_r[0][1]) - CRW'(pp_2_r[1][0]);
    for (int i = 0; i < 3; i++) begin
      ec[i]   = EW'(dl_2_r[i]) - (EW'(d0_2_r[i]) <<< DF);
      sv[i]   = AW'(cr[i]);
      sv[i+3] = AW'(ec[i]);
    end
    for (int k = 0; k < NL; k++) begin
      mag_nxt[k] = sv[k][AW-1] ? (AW'(~sv[k]) + AW'(1)) : AW'(sv[k]);
    end
  end

  assign tproj  = TW'(pp_2_r[0][0]) + TW'(pp_2_r[1][1]) + TW'(pp_2_r[2][2]);
  assign len_sc = $signed({{(TW-RW-DF){1'b0}}, len_2_r, {DF{1'b0}}});
  // closest point behind the origin or past the segment end
  assign tf_nxt = nz_2_r && (tproj[TW-1] || (tproj > len_sc));

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      mag_3_r <= mag_nxt;
      tf_3_r  <= tf_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: split squaring, half-width partial products.
  // --------------------------------------------------------------------------
  logic [2*HIW-1:0] hh_nxt  [NL];
  logic [AW-1:0]    hl_nxt  [NL];
  logic [2*H-1:0]   ll_nxt  [NL];
  logic [2*HIW-1:0] hh_4_r  [NL];
  logic [AW-1:0]    hl_4_r  [NL];
  logic [2*H-1:0]   ll_4_r  [NL];
  logic             tf_4_r;

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      hh_nxt[k] = (2*HIW)'(mag_3_r[k][AW-1:H]) * (2*HIW)'(mag_3_r[k][AW-1:H]);
      hl_nxt[k] = AW'(mag_3_r[k][AW-1:H]) * AW'(mag_3_r[k][H-1:0]);
      ll_nxt[k] = (2*H)'(mag_3_r[k][H-1:0]) * (2*H)'(mag_3_r[k][H-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      hh_4_r <= hh_nxt;
      hl_4_r <= hl_nxt;
      ll_4_r <= ll_nxt;
      tf_4_r <= tf_3_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: recombine partials into full squares.
  // --------------------------------------------------------------------------
  logic [SQW-1:0] sq_nxt [NL];
  logic [SQW-1:0] sq_5_r [NL];
  logic           tf_5_r;

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      sq_nxt[k] = (SQW'(hh_4_r[k]) << (2*H)) + (SQW'(hl_4_r[k]) << (H+1))
                + SQW'(ll_4_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      sq_5_r <= sq_nxt;
      tf_5_r <= tf_4_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: squared lengths |d0 x w|^2 and |w*len - d0*S|^2.
  // --------------------------------------------------------------------------
  logic [SUMW-1:0] sc_nxt;
  logic [SUMW-1:0] se_nxt;
  logic [SUMW-1:0] sc_6_r;
  logic [SUMW-1:0] se_6_r;
  logic            tf_6_r;

  assign sc_nxt = SUMW'(sq_5_r[0]) + SUMW'(sq_5_r[1]) + SUMW'(sq_5_r[2]);
  assign se_nxt = SUMW'(sq_5_r[3]) + SUMW'(sq_5_r[4]) + SUMW'(sq_5_r[5]);

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      sc_6_r <= sc_nxt;
      se_6_r <= se_nxt;
      tf_6_r <= tf_5_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7 (output register): compare against (radius*S)^2. Ties are not
  // outside. Miss if off the body, or if the end point is beyond the bound
  // and the closest point is not on the segment.
  // --------------------------------------------------------------------------
  logic [SUMW-1:0] body_lim;
  logic [SUMW-1:0] bound_lim;
  logic            hit_nxt;
  logic            hit_7_r;

  assign body_lim  = SUMW'({body_sq_r,  {(2*DF){1'b0}}});
  assign bound_lim = SUMW'({bound_sq_r, {(2*DF){1'b0}}});
  assign hit_nxt   = !((sc_6_r > body_lim) || ((se_6_r > bound_lim) && tf_6_r));

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      hit_7_r <= hit_nxt;
    end
  end

  assign out_hit = hit_7_r;

endmodule

`default_nettype wire

[design/ssht_chk.sv]
// ============================================================================
// ssht_chk
// Port-level checks for segment_sphere_hit_test, bound to the top level.
// ============================================================================
`default_nettype none

module ssht_chk (
  input wire clk,
  input wire rst_n,
  input wire in_valid,
  input wire in_stall,
  input wire out_valid,
  input wire out_stall,
  input wire out_hit
);

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_hit)))
    else $error("stalled result changed");

  // input backs up only behind a stalled, valid output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  // an accepted input reaches out_valid when the output side keeps draining
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
      ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind segment_sphere_hit_test ssht_chk u_ssht_chk (.*);

`default_nettype wire

[test/segment_sphere_hit_test_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// segment_sphere_hit_test_tb
// Self-checking bench for the segment/sphere hit test. A table of directed
// rays runs first, then randomized rays aimed around a series of sphere
// settings. Rays without a typed result are predicted with exact 128-bit integer
// math and each result transaction is checked in order against its expected hit flag.
// ============================================================================

module segment_sphere_hit_test_tb;
  import ssht_pkg::*;

  localparam int FRAC_BITS        = 14;
  localparam int CYCLE_LIMIT      = 300000;
  localparam int RANDOM_PHASES    = 8;
  localparam int RAYS_PER_PHASE   = 94;

  typedef logic signed [31:0]  coord_t;
  typedef logic signed [15:0]  dir_t;
  typedef logic        [30:0]  len_t;
  typedef logic signed [127:0] wide_t;   // holds every product below exactly

  localparam coord_t COORD_MAX    = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN    = 32'sh8000_0000;
  localparam len_t   LEN_MAX      = 31'h7FFF_FFFF;
  localparam dir_t   DIR_ONE      = 16'sd16384;
  localparam dir_t   DIR_MOST_POS = 16'sh7FFF;
  localparam dir_t   DIR_MOST_NEG = 16'sh8000;
  localparam wide_t  SCALE        = wide_t'(1) <<< FRAC_BITS;

  // indexes past the register list; writes there must be ignored
  localparam cfg_addr_t CFG_SPARE_FIRST = CFG_BOUND_RADIUS + 3'd1;
  localparam cfg_addr_t CFG_SPARE_LAST  = '1;

  typedef struct {
    coord_t cx, cy, cz;
    len_t   body, bound;
  } sphere_t;

  typedef struct {
    coord_t ox, oy, oz;
    dir_t   wx, wy, wz;
    len_t   len;
  } ray_t;

  // one directed row: optional sphere reload, the ray, optional typed result
  typedef struct {
    bit      load;
    sphere_t sph;
    ray_t    ray;
    bit      known;
    bit      hit;
  } probe_t;

  // --------------------------------------------------------------------------
  // DUT signals; the inputs are all driven to known values from time zero
  // --------------------------------------------------------------------------
  logic      clk;
  logic      rst_n         = 1'b0;
  logic      cfg_wr_en     = 1'b0;
  cfg_addr_t cfg_addr      = CFG_CENTER_X;
  logic [31:0] cfg_data    = '0;
  logic      in_valid      = 1'b0;
  logic      in_stall;
  coord_t    in_origin_x   = '0;
  coord_t    in_origin_y   = '0;
  coord_t    in_origin_z   = '0;
  dir_t      in_dir_x      = '0;
  dir_t      in_dir_y      = '0;
  dir_t      in_dir_z      = '0;
  len_t      in_seg_length = '0;
  logic      out_valid;
  logic      out_stall     = 1'b0;
  logic      out_hit;

  segment_sphere_hit_test uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_origin_x   (in_origin_x),
    .in_origin_y   (in_origin_y),
    .in_origin_z   (in_origin_z),
    .in_dir_x      (in_dir_x),
    .in_dir_y      (in_dir_y),
    .in_dir_z      (in_dir_z),
    .in_seg_length (in_seg_length),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  sphere_t cur_sphere;          // shadow of the sphere registers
  bit      pending_hits[$];     // expected hit flag per accepted ray, oldest first
  probe_t  directed_rows[$];
  bit      steady = 1'b0;       // when set, neither side idles
  bit      want;
  int      mismatches   = 0;
  int      rays_sent    = 0;
  int      hits_seen    = 0;
  int      misses_seen  = 0;
  int      sphere_loads = 0;
  int      cycles       = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction: exact integer version of the hit test, everything scaled by
  // 2^FRAC_BITS and compared as squares so nothing rounds.
  // --------------------------------------------------------------------------
  function automatic bit predict_hit(sphere_t s, ray_t r);
    wide_t qx, qy, qz, wx, wy, wz, len;
    wide_t px, py, pz, ex, ey, ez, rb, rd, t;
    qx  = wide_t'(s.cx) - wide_t'(r.ox);   // center relative to origin
    qy  = wide_t'(s.cy) - wide_t'(r.oy);
    qz  = wide_t'(s.cz) - wide_t'(r.oz);
    wx  = wide_t'(r.wx);
    wy  = wide_t'(r.wy);
    wz  = wide_t'(r.wz);
    len = wide_t'(r.len);
    // perpendicular distance from the cross product
    px  = qy * wz - qz * wy;
    py  = qz * wx - qx * wz;
    pz  = qx * wy - qy * wx;
    rb  = wide_t'(s.body) * SCALE;
    if (rb * rb < px * px + py * py + pz * pz)
      return 1'b0;
    // segment end relative to center
    ex  = wx * len - qx * SCALE;
    ey  = wy * len - qy * SCALE;
    ez  = wz * len - qz * SCALE;
    rd  = wide_t'(s.bound) * SCALE;
    if (rd * rd < ex * ex + ey * ey + ez * ez) begin
      // end is outside the bound: closest point must lie on the segment;
      // a zero direction cannot fail this
      t = qx * wx + qy * wy + qz * wz;
      if ((wx != 0 || wy != 0 || wz != 0) && (t < 0 || len * SCALE < t))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Builders and random helpers
  // --------------------------------------------------------------------------
  function automatic sphere_t mk_sphere(coord_t cx, coord_t cy, coord_t cz,
                                        len_t body, len_t bound);
    sphere_t s;
    s.cx = cx; s.cy = cy; s.cz = cz;
    s.body = body; s.bound = bound;
    return s;
  endfunction

  function automatic ray_t mk_ray(coord_t ox, coord_t oy, coord_t oz,
                                  dir_t wx, dir_t wy, dir_t wz, len_t len);
    ray_t r;
    r.ox = ox; r.oy = oy; r.oz = oz;
    r.wx = wx; r.wy = wy; r.wz = wz;
    r.len = len;
    return r;
  endfunction

  task automatic add_row(bit load, sphere_t s, ray_t r, bit known, bit hit);
    probe_t p;
    p.load = load; p.sph = s; p.ray = r; p.known = known; p.hit = hit;
    directed_rows.push_back(p);
  endtask

  function automatic real rnd_unit();
    return ($urandom_range(0, 2000000) - 1000000.0) / 1000000.0;
  endfunction

  function automatic coord_t rand_near(int n);
    return int'($urandom_range(0, 2 * n)) - n;
  endfunction

  function automatic coord_t to_coord(real v);
    if (v >= 2147483647.0) return COORD_MAX;
    if (v <= -2147483648.0) return COORD_MIN;
    return $rtoi(v);
  endfunction

  function automatic dir_t to_dir(real v);
    if (v > 16384.0) return DIR_ONE;
    if (v < -16384.0) return -DIR_ONE;
    return dir_t'($rtoi(v));
  endfunction

  function automatic len_t to_len(real v);
    if (v >= 2147483647.0) return LEN_MAX;
    if (v <= 0.0) return '0;
    return len_t'($rtoi(v));
  endfunction

  // sphere setting per random phase; extremes are mixed in on purpose
  function automatic sphere_t pick_sphere(int phase);
    len_t b;
    b = len_t'($urandom_range(1, 2000));
    case (phase)
      1:       return mk_sphere($urandom, $urandom, $urandom,
                                len_t'($urandom_range(0, 1 << 24)),
                                len_t'($urandom_range(0, 1 << 24)));
      2:       return mk_sphere(COORD_MAX, COORD_MAX, COORD_MAX, LEN_MAX, LEN_MAX);
      3:       return mk_sphere(COORD_MIN, COORD_MIN, COORD_MIN, '0, '0);
      4: begin
        b = len_t'($urandom_range(1, 1000000));
        return mk_sphere(rand_near(100000), rand_near(100000), rand_near(100000), b, b / 2);
      end
      5:       return mk_sphere($urandom, $urandom, $urandom,
                                len_t'($urandom), len_t'($urandom));
      6:       return mk_sphere(rand_near(100), rand_near(100), rand_near(100),
                                len_t'($urandom_range(1, 20)),
                                len_t'($urandom_range(1, 40)));
      7:       return mk_sphere(rand_near(1 << 20), rand_near(1 << 20), rand_near(1 << 20),
                                LEN_MAX, '0);
      default: return mk_sphere(rand_near(10000), rand_near(10000), rand_near(10000),
                                b, b + len_t'($urandom_range(0, 2000)));
    endcase
  endfunction

  // Most rays are aimed near the sphere so both radius tests and the
  // between test get real traffic; the rest are noise or odd directions.
  function automatic ray_t make_ray(sphere_t s);
    ray_t r;
    int   kind;
    real  rad, span, jit, vx, vy, vz, n;
    kind = $urandom_range(0, 9);
    if (kind == 6) begin
      // pure noise over the full field ranges
      r = mk_ray($urandom, $urandom, $urandom,
                 dir_t'($urandom), dir_t'($urandom), dir_t'($urandom),
                 len_t'($urandom));
      return r;
    end
    rad = s.body;
    if (s.bound > rad) rad = s.bound;
    if (rad < 16.0) rad = 16.0;
    span = rad * (0.5 + $urandom_range(0, 7));
    r.ox = to_coord(s.cx + span * rnd_unit());
    r.oy = to_coord(s.cy + span * rnd_unit());
    r.oz = to_coord(s.cz + span * rnd_unit());
    if (kind == 9 && $urandom_range(0, 1)) begin
      r.ox = s.cx; r.oy = s.cy; r.oz = s.cz;
    end
    // aim at the center, pushed sideways by up to 1.5 radii
    jit = rad * $urandom_range(0, 150) / 100.0;
    vx  = (real'(s.cx) - real'(r.ox)) + jit * rnd_unit();
    vy  = (real'(s.cy) - real'(r.oy)) + jit * rnd_unit();
    vz  = (real'(s.cz) - real'(r.oz)) + jit * rnd_unit();
    n   = $sqrt(vx * vx + vy * vy + vz * vz);
    if (n < 1.0) begin
      vx = rnd_unit(); vy = rnd_unit(); vz = rnd_unit();
      n  = $sqrt(vx * vx + vy * vy + vz * vz) + 1.0e-9;
    end
    r.wx  = to_dir(vx * 16384.0 / n);
    r.wy  = to_dir(vy * 16384.0 / n);
    r.wz  = to_dir(vz * 16384.0 / n);
    r.len = to_len((2.0 * n + 2.0 * rad) * $urandom_range(0, 1000) / 1000.0);
    case (kind)
      7: begin
        r.wx = '0; r.wy = '0; r.wz = '0;
      end
      8: begin
        // raw codes: non-unit lengths, sometimes the most negative code
        r.wx = dir_t'($urandom); r.wy = dir_t'($urandom); r.wz = dir_t'($urandom);
        if ($urandom_range(0, 3) == 0) r.wy = DIR_MOST_NEG;
      end
      9: if ($urandom_range(0, 1)) r.len = '0;
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Loads all five sphere registers plus one write to a spare index.
  // Only called with the pipe empty.
  task automatic write_sphere(sphere_t s);
    bit msb;
    cfg_wr_en <= 1'b1;
    cfg_addr  <= CFG_CENTER_X;     cfg_data <= s.cx;
    @(posedge clk);
    cfg_addr  <= CFG_CENTER_Y;     cfg_data <= s.cy;
    @(posedge clk);
    cfg_addr  <= CFG_CENTER_Z;     cfg_data <= s.cz;
    @(posedge clk);
    msb = 1'($urandom_range(0, 1));    // top data bit is outside the radius field
    cfg_addr  <= CFG_BODY_RADIUS;  cfg_data <= {msb, s.body};
    @(posedge clk);
    msb = 1'($urandom_range(0, 1));
    cfg_addr  <= CFG_BOUND_RADIUS; cfg_data <= {msb, s.bound};
    @(posedge clk);
    cfg_addr  <= cfg_addr_t'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST));
    cfg_data  <= $urandom;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_sphere = s;
    sphere_loads++;
  endtask

  // Offers one ray transaction after a random idle gap (none when steady is set)
  // and records its expected hit flag once it is accepted.
  task automatic send_ray(ray_t r, bit given, bit given_hit);
    int gap;
    bit want_hit;
    gap      = steady ? 0 : $urandom_range(0, 5);
    want_hit = given ? given_hit : predict_hit(cur_sphere, r);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_origin_x   <= r.ox;
    in_origin_y   <= r.oy;
    in_origin_z   <= r.oz;
    in_dir_x      <= r.wx;
    in_dir_y      <= r.wy;
    in_dir_z      <= r.wz;
    in_seg_length <= r.len;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_hits.push_back(want_hit);
    rays_sent++;
  endtask

  // Stops sending and waits for every outstanding result, then lets the
  // pipe run empty.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (PIPE_STAGES + 2) @(posedge clk);
  endtask

  // Result side: unless steady, stall for a random count of cycles, then take one transaction.
  initial begin : result_pacer
    int hold;
    forever begin
      hold = steady ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // --------------------------------------------------------------------------
  // Checker: every accepted result against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, actual hit=%b",
                 $time, out_hit);
        mismatches++;
      end else begin
        want = pending_hits.pop_front();
        if (out_hit !== want) begin
          $display("%0t: hit mismatch, expected %b, actual %b", $time, want, out_hit);
          mismatches++;
        end
        if (want) hits_seen++;
        else      misses_seen++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("[segment_sphere_hit_test] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    sphere_t s_zero, s_small, s_edge, s_floor;
    ray_t    r;
    s_zero  = mk_sphere('0, '0, '0, '0, '0);
    s_small = mk_sphere(100, -200, 300, 50, 80);
    s_edge  = mk_sphere(COORD_MAX, COORD_MIN, COORD_MAX, LEN_MAX, LEN_MAX);
    s_floor = mk_sphere(COORD_MIN, COORD_MAX, COORD_MIN, '0, '0);
    cur_sphere = s_zero;            // registers come out of reset at zero

    // -- directed rows; typed results only where obvious --
    // reset sphere: point at the origin, both radii zero
    add_row(0, s_zero, mk_ray(0, 0, 0, 0, 0, 0, 0), 1, 1);
    add_row(0, s_zero, mk_ray(1, 0, 0, DIR_ONE, 0, 0, 0), 1, 0);        // closest point behind
    add_row(0, s_zero, mk_ray(1, 0, 0, -DIR_ONE, 0, 0, 1), 1, 1);       // ends on the center
    add_row(0, s_zero, mk_ray(0, 1, 0, DIR_ONE, 0, 0, 5), 1, 0);        // perpendicular miss
    add_row(0, s_zero, mk_ray(0, 0, 0, 0, 0, 0, LEN_MAX), 1, 1);
    add_row(0, s_zero, mk_ray(5, 0, 0, 0, 0, 0, 7), 1, 1);              // zero direction
    add_row(0, s_zero, mk_ray(COORD_MIN, COORD_MIN, COORD_MIN,
                              DIR_MOST_NEG, DIR_MOST_NEG, DIR_MOST_NEG, LEN_MAX), 0, 0);
    add_row(0, s_zero, mk_ray(COORD_MAX, COORD_MAX, COORD_MAX,
                              DIR_ONE, DIR_ONE, DIR_ONE, LEN_MAX), 0, 0);
    // small sphere at (100,-200,300), body 50, bound 80
    add_row(1, s_small, mk_ray(100, -150, 0, 0, 0, DIR_ONE, 300), 0, 0); // body tie
    add_row(0, s_small, mk_ray(100, -251, 0, 0, 0, DIR_ONE, 300), 0, 0); // just past body
    add_row(0, s_small, mk_ray(100, -200, 0, 0, 0, DIR_ONE, 1000), 0, 0); // passes through
    add_row(0, s_small, mk_ray(100, -200, 0, 0, 0, -DIR_ONE, 1000), 0, 0); // points away
    add_row(0, s_small, mk_ray(100, -200, 0, 0, 0, DIR_ONE, 100), 0, 0); // stops short
    add_row(0, s_small, mk_ray(100, -200, 0, 0, 0, DIR_ONE, 220), 0, 0); // bound tie
    add_row(0, s_small, mk_ray(100, -200, 0, 0, 0, DIR_ONE, 219), 0, 0);
    add_row(0, s_small, mk_ray(100, -200, 0, 0, 0, DIR_ONE / 2, 440), 0, 0); // half length w
    add_row(0, s_small, mk_ray(100, -200, 420, 0, 0, 0, 9), 0, 0);      // zero dir, far out
    add_row(0, s_small, mk_ray(100, -200, 0, 0, 0, DIR_MOST_NEG, 150), 0, 0);
    add_row(0, s_small, mk_ray(100, -200, 0, 0, 0, DIR_MOST_POS, 150), 0, 0);
    // extreme center and radii
    add_row(1, s_edge, mk_ray(COORD_MIN, COORD_MAX, COORD_MIN,
                              DIR_ONE, -DIR_ONE, DIR_ONE, LEN_MAX), 0, 0);
    add_row(0, s_edge, mk_ray(COORD_MAX, COORD_MIN, COORD_MAX, 0, 0, 0, 0), 1, 1);
    add_row(1, s_floor, mk_ray(COORD_MIN, COORD_MAX, COORD_MIN, DIR_ONE, 0, 0, 0), 1, 1);
    add_row(0, s_floor, mk_ray(COORD_MIN, COORD_MAX, COORD_MIN, DIR_ONE, 0, 0, 1), 0, 0);
    add_row(0, s_floor, mk_ray(COORD_MAX, COORD_MIN, COORD_MAX,
                               DIR_MOST_NEG, DIR_MOST_NEG, DIR_MOST_NEG, LEN_MAX), 0, 0);

    // hold reset, then release it
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].load) begin
        drain_pipe();
        write_sphere(directed_rows[k].sph);
      end
      send_ray(directed_rows[k].ray, directed_rows[k].known, directed_rows[k].hit);
    end

    // -- random phases, each with its own sphere; the drain before each load
    //    also holds the sender off until all results are back --
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_pipe();
      steady = (p == 2 || p == 6);  // back-to-back stretches with no idling
      write_sphere(pick_sphere(p));
      for (int i = 0; i < RAYS_PER_PHASE; i++) begin
        r = make_ray(cur_sphere);
        send_ray(r, 1'b0, 1'b0);
      end
    end
    steady = 1'b0;

    drain_pipe();
    $display("Checked %0d ray transactions under %0d sphere settings (%0d hits, %0d misses).",
             rays_sent, sphere_loads + 1, hits_seen, misses_seen);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("[segment_sphere_hit_test] OK");
    end else begin
      $display("[segment_sphere_hit_test] ERROR");
    end
    $finish;
  end

endmodule
